/* sv/gtd_pkg.sv */
package gtd_pkg;

   // Defaults for the top-level parameters.
   localparam int TEMPLATE_LEN_DEF = 40;
   localparam int SAMPLE_FRAC_DEF  = 8;

   // Fixed sizes.
   localparam int PEAK_WINDOW = 5;
   localparam int ROM_LEN     = 40;
   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 24;
   localparam int UNIT_W      = 16;
   localparam int LIMIT_W     = 16;
   localparam int COUNT_W     = 7;
   localparam int ENERGY_W    = 32;
   localparam int ROM_W       = 20;
   localparam int CSR_IDX_W   = 3;

   // Register reset values.
   localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RST      = 16'd2000;
   localparam logic [LIMIT_W-1:0] PERP_ERROR_LIMIT_RST = 16'd2500;
   localparam logic [LIMIT_W-1:0] HIT_LEVEL_RST        = 16'd800;
   localparam logic [LIMIT_W-1:0] HIT_RISE_RST         = 16'd400;
   localparam logic [COUNT_W-1:0] SETTLE_RST           = 7'd40;
   localparam logic [COUNT_W-1:0] CALIB_END_RST        = 7'd80;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ERROR_LIMIT      = 3'd0,
      CSR_PERP_ERROR_LIMIT = 3'd1,
      CSR_HIT_LEVEL        = 3'd2,
      CSR_HIT_RISE         = 3'd3,
      CSR_SETTLE_SAMPLES   = 3'd4,
      CSR_CALIB_END        = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_CALIB  = 2'd0,
      PHASE_NORM   = 2'd1,
      PHASE_DETECT = 2'd2
   } phase_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CAL, ST_NSQ, ST_NCHK, ST_NSHIFT, ST_SQRT, ST_DIVINIT, ST_DIV,
      ST_DIVEND, ST_DOT, ST_AXIS, ST_PERP, ST_ENERGY, ST_WRITE, ST_WSTART,
      ST_WA, ST_WB, ST_WEND, ST_DONE
   } state_type;

   localparam logic signed [15:0] AXIAL_ROM [ROM_LEN] = '{
      -16'sd4142, -16'sd4314, -16'sd4513, -16'sd4748, -16'sd4992,
      -16'sd5181, -16'sd5363, -16'sd5482, -16'sd5471, -16'sd5195,
      -16'sd4621, -16'sd3773, -16'sd2876, -16'sd1972, -16'sd1169,
      -16'sd435,   16'sd241,   16'sd1006,  16'sd1450,  16'sd1774,
       16'sd1898,  16'sd1779,  16'sd1438,  16'sd923,   16'sd276,
      -16'sd410,  -16'sd1113, -16'sd1848, -16'sd2555, -16'sd3219,
      -16'sd3830, -16'sd4327, -16'sd4626, -16'sd4854, -16'sd4909,
      -16'sd4884, -16'sd4783, -16'sd4601, -16'sd4480, -16'sd4359};

   localparam logic signed [15:0] PERP_ROM [ROM_LEN] = '{
      16'sd4412, 16'sd4126, 16'sd3684, 16'sd3141, 16'sd2588,
      16'sd2175, 16'sd1874, 16'sd1718, 16'sd1703, 16'sd1843,
      16'sd2000, 16'sd2161, 16'sd2287, 16'sd2397, 16'sd2575,
      16'sd2878, 16'sd3622, 16'sd4439, 16'sd4907, 16'sd5126,
      16'sd5105, 16'sd4872, 16'sd4445, 16'sd3829, 16'sd3175,
      16'sd2631, 16'sd2097, 16'sd1683, 16'sd1429, 16'sd1288,
      16'sd1250, 16'sd1288, 16'sd1384, 16'sd1615, 16'sd1733,
      16'sd1889, 16'sd2117, 16'sd2539, 16'sd2786, 16'sd3066};

   // Template entries past the stored ones read as zero.
   function automatic logic signed [15:0] rom_axial(input logic [5:0] k);
      if (k < 6'(ROM_LEN)) return AXIAL_ROM[k];
      return 16'sd0;
   endfunction

   function automatic logic signed [15:0] rom_perp(input logic [5:0] k);
      if (k < 6'(ROM_LEN)) return PERP_ROM[k];
      return 16'sd0;
   endfunction

   // Rescale a Q.8 template value to the sample format, rounding to nearest.
   function automatic logic signed [ROM_W-1:0] rom_scale(input logic signed [15:0] v,
                                                        input int frac);
      logic signed [ROM_W-1:0] w;
      w = ROM_W'(v);
      if (frac >= 8) return w <<< (frac - 8);
      return (w + (ROM_W'(1) <<< (7 - frac))) >>> (8 - frac);
   endfunction

endpackage

/* sv/accel_gesture_template_detector_core.sv */
// A calibration beat updates the gravity sums; the normalizing beat runs the square sums, the
// normalizing shift, 31 square-root steps and 3 divisions of 17 steps.
// Detection beats project the sample, take its energy and then walk the template.
// Throughput: one beat at a time; req_tready is high only while the sequencer is idle.
// Reset (synchronous, active high) clears the control state and restores register defaults.
module accel_gesture_template_detector_core #(
   parameter int TEMPLATE_LEN     = gtd_pkg::TEMPLATE_LEN_DEF,
   parameter int SAMPLE_FRAC_BITS = gtd_pkg::SAMPLE_FRAC_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // phase[1:0], template_match[2], hit_detected[3], zero
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // The whole block runs as a small sequencer around one shared 25x25 multiplier and one
   // shared 64-bit compare-and-subtract unit. The subtractor serves the restoring square
   // root and the restoring divider; the multiplier serves every product.
   localparam int PTR_W   = $clog2(TEMPLATE_LEN);
   localparam int LIM_SH  = 2 * SAMPLE_FRAC_BITS;
   localparam int ERR_W   = 48;
   localparam int MUL_W   = 25;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int WIDE_W  = 64;
   localparam int DIFF_W  = 21;
   localparam int Q_W     = 17;
   localparam int S_W     = gtd_pkg::SAMPLE_W;
   localparam int G_W     = gtd_pkg::SUM_W;
   localparam int U_W     = gtd_pkg::UNIT_W;
   localparam int E_W     = gtd_pkg::ENERGY_W;
   localparam int PW      = gtd_pkg::PEAK_WINDOW;
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(TEMPLATE_LEN - 1);

   // Configuration registers.
   logic [gtd_pkg::LIMIT_W-1:0] err_lim_ff, perp_lim_ff, hit_level_ff, hit_rise_ff;
   logic [gtd_pkg::COUNT_W-1:0] settle_ff, calib_end_ff;

   gtd_pkg::state_type state_ff, state_in;
   gtd_pkg::phase_type phase_ff, phase_in;

   logic signed [S_W-1:0]    v_ff [3], v_in [3];
   logic signed [G_W-1:0]    gsum_ff [3], gsum_in [3];
   logic signed [U_W-1:0]    unit_ff [3], unit_in [3];
   logic [E_W-1:0]           energy_ff [PW], energy_in [PW];
   logic [gtd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                     norm_ff, norm_in;
   logic [PTR_W-1:0]         k_ff, k_in;
   logic [1:0]               sub_ff, sub_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [WIDE_W-1:0] acc_ff, acc_in;
   logic [4:0]               h_ff, h_in;
   logic [WIDE_W-1:0]        sq_n_ff, sq_n_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [WIDE_W-1:0]        rem_ff, rem_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic [4:0]               i_ff, i_in;
   logic signed [S_W-1:0]    ax_ff, ax_in;
   logic signed [DIFF_W-1:0] dd_ff, dd_in;
   logic [PTR_W-1:0]         ptr_ff, ptr_in, rd_idx_ff, rd_idx_in;
   logic [TEMPLATE_LEN-1:0]  valid_ff, valid_in;
   logic                     rvalid_ff, rvalid_in;
   logic [ERR_W-1:0]         err_ff, err_in, errp_ff, errp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_phase_ff, rsp_phase_in;
   logic                     rsp_match_ff, rsp_match_in, rsp_hit_ff, rsp_hit_in;

   // Shared units.
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [WIDE_W-1:0]        sub_a, sub_b;
   logic [WIDE_W:0]          sub_diff;
   logic                     sub_ge;

   // Ring memory port.
   logic             ram_wr_en, ram_rd_en;
   logic [PTR_W-1:0] ram_rd_addr;
   logic [31:0]      ram_wr_data, ram_rd_data;

   // Helpers.
   logic [1:0]               ax;
   logic                     accept, rsp_load;
   logic signed [WIDE_W-1:0] acc_rnd;
   logic signed [S_W-1:0]    ax_sat;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [DIFF_W-1:0] perp_diff;
   logic [G_W-1:0]           gabs;
   logic [WIDE_W-1:0]        dividend;
   logic [U_W-1:0]           q_sat;
   logic [15:0]              perp_sat;
   logic signed [S_W-1:0]    ent_ax;
   logic [15:0]              ent_pp;
   logic signed [DIFF_W-1:0] rom_ax_s, rom_pp_s, ent_ax_s, ent_pp_s, d_ax, d_pp;
   logic                     match_now, hit_now;
   logic [ERR_W-1:0]         lim_ax, lim_pp, lvl, mid;
   logic signed [ERR_W-1:0]  rise, rise_d [4];

   assign accept     = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == gtd_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign ax         = (k_ff[1:0] == 2'd3) ? 2'd0 : k_ff[1:0];
   assign mul_p      = mul_a * mul_b;
   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge     = !sub_diff[WIDE_W];

   assign acc_rnd    = (acc_ff + WIDE_W'(8192)) >>> 14;
   assign ax_sat     = (acc_rnd > WIDE_W'(32767)) ? 16'sh7FFF :
                       (acc_rnd < -WIDE_W'(32768)) ? 16'sh8000 : S_W'(acc_rnd);
   assign prod_rnd   = (prod_ff + PROD_W'(8192)) >>> 14;
   assign perp_diff  = DIFF_W'(v_ff[ax]) - DIFF_W'(prod_rnd);
   assign gabs       = gsum_ff[ax][G_W-1] ? G_W'(-gsum_ff[ax]) : G_W'(gsum_ff[ax]);
   assign dividend   = (WIDE_W'(gabs) << (6'd14 + 6'(h_ff))) + (sq_r_ff >> 1);
   assign q_sat      = (q_ff > Q_W'(32767)) ? 16'd32767 : q_ff[U_W-1:0];
   assign perp_sat   = (sq_r_ff > WIDE_W'(65535)) ? 16'hFFFF : sq_r_ff[15:0];

   // Entries never written read as the cleared value.
   assign ent_ax     = rvalid_ff ? $signed(ram_rd_data[15:0]) : 16'sd0;
   assign ent_pp     = rvalid_ff ? ram_rd_data[31:16] : 16'd0;
   assign rom_ax_s   = DIFF_W'(gtd_pkg::rom_scale(gtd_pkg::rom_axial(6'(k_ff)),
                                                  SAMPLE_FRAC_BITS));
   assign rom_pp_s   = DIFF_W'(gtd_pkg::rom_scale(gtd_pkg::rom_perp(6'(k_ff)),
                                                  SAMPLE_FRAC_BITS));
   assign ent_ax_s   = DIFF_W'(ent_ax);
   assign ent_pp_s   = $signed(DIFF_W'(ent_pp));
   assign d_ax       = rom_ax_s - ent_ax_s;
   assign d_pp       = rom_pp_s - ent_pp_s;

   // Decision logic: limits are whole squared units.
   assign lim_ax     = ERR_W'(err_lim_ff) << LIM_SH;
   assign lim_pp     = ERR_W'(perp_lim_ff) << LIM_SH;
   assign lvl        = ERR_W'(hit_level_ff) << LIM_SH;
   assign rise       = $signed(ERR_W'(hit_rise_ff) << LIM_SH);
   assign mid        = ERR_W'(energy_ff[2]);
   assign rise_d[0]  = $signed(mid) - $signed(ERR_W'(energy_ff[0]));
   assign rise_d[1]  = $signed(mid) - $signed(ERR_W'(energy_ff[1]));
   assign rise_d[2]  = $signed(mid) - $signed(ERR_W'(energy_ff[3]));
   assign rise_d[3]  = $signed(mid) - $signed(ERR_W'(energy_ff[4]));
   assign match_now  = (err_ff < lim_ax) && (errp_ff < lim_pp);
   assign hit_now    = (mid > lvl) &&
                       (((rise_d[1] > rise) && (rise_d[3] > rise)) ||
                        ((rise_d[2] > rise) && (rise_d[0] > rise)) ||
                        ((rise_d[2] > rise) && (rise_d[1] > rise)));

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         err_lim_ff   <= gtd_pkg::ERROR_LIMIT_RST;
         perp_lim_ff  <= gtd_pkg::PERP_ERROR_LIMIT_RST;
         hit_level_ff <= gtd_pkg::HIT_LEVEL_RST;
         hit_rise_ff  <= gtd_pkg::HIT_RISE_RST;
         settle_ff    <= gtd_pkg::SETTLE_RST;
         calib_end_ff <= gtd_pkg::CALIB_END_RST;
      end else if (csr_wen) begin
         unique case (gtd_pkg::csr_index_type'(csr_index))
            gtd_pkg::CSR_ERROR_LIMIT:      err_lim_ff   <= csr_wdata;
            gtd_pkg::CSR_PERP_ERROR_LIMIT: perp_lim_ff  <= csr_wdata;
            gtd_pkg::CSR_HIT_LEVEL:        hit_level_ff <= csr_wdata;
            gtd_pkg::CSR_HIT_RISE:         hit_rise_ff  <= csr_wdata;
            gtd_pkg::CSR_SETTLE_SAMPLES:   settle_ff    <= csr_wdata[6:0];
            gtd_pkg::CSR_CALIB_END:        calib_end_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gtd_pkg::ST_IDLE: begin
            if (accept) begin
               if (norm_ff) state_in = gtd_pkg::ST_DOT;
               else if (count_ff < calib_end_ff) state_in = gtd_pkg::ST_CAL;
               else state_in = gtd_pkg::ST_NSQ;
            end
         end
         gtd_pkg::ST_CAL:    state_in = gtd_pkg::ST_DONE;
         gtd_pkg::ST_NSQ:    if (k_ff == PTR_W'(3)) state_in = gtd_pkg::ST_NCHK;
         gtd_pkg::ST_NCHK:   state_in = (acc_ff == '0) ? gtd_pkg::ST_DONE : gtd_pkg::ST_NSHIFT;
         gtd_pkg::ST_NSHIFT: if (acc_ff[WIDE_W-1:60] != '0) state_in = gtd_pkg::ST_SQRT;
         gtd_pkg::ST_SQRT: begin
            if (sq_bit_ff[0]) state_in = norm_ff ? gtd_pkg::ST_ENERGY : gtd_pkg::ST_DIVINIT;
         end
         gtd_pkg::ST_DIVINIT: state_in = gtd_pkg::ST_DIV;
         gtd_pkg::ST_DIV:     if (i_ff == '0) state_in = gtd_pkg::ST_DIVEND;
         gtd_pkg::ST_DIVEND: begin
            state_in = (k_ff == PTR_W'(2)) ? gtd_pkg::ST_DONE : gtd_pkg::ST_DIVINIT;
         end
         gtd_pkg::ST_DOT:    if (k_ff == PTR_W'(3)) state_in = gtd_pkg::ST_AXIS;
         gtd_pkg::ST_AXIS:   state_in = gtd_pkg::ST_PERP;
         gtd_pkg::ST_PERP:   if (k_ff == PTR_W'(3)) state_in = gtd_pkg::ST_SQRT;
         gtd_pkg::ST_ENERGY: if (k_ff == PTR_W'(3)) state_in = gtd_pkg::ST_WRITE;
         gtd_pkg::ST_WRITE:  state_in = gtd_pkg::ST_WSTART;
         gtd_pkg::ST_WSTART: state_in = gtd_pkg::ST_WA;
         gtd_pkg::ST_WA:     state_in = gtd_pkg::ST_WB;
         gtd_pkg::ST_WB:     state_in = (k_ff == LAST_IDX) ? gtd_pkg::ST_WEND : gtd_pkg::ST_WA;
         gtd_pkg::ST_WEND:   state_in = gtd_pkg::ST_DONE;
         gtd_pkg::ST_DONE:   if (rsp_load) state_in = gtd_pkg::ST_IDLE;
         default:            state_in = gtd_pkg::ST_IDLE;
      endcase
   end

   // Unit operands and memory controls.
   always_comb begin
      req_tready  = (state_ff == gtd_pkg::ST_IDLE);
      mul_a       = '0;
      mul_b       = '0;
      sub_a       = '0;
      sub_b       = '0;
      ram_wr_en   = 1'b0;
      ram_wr_data = {perp_sat, ax_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff;
      unique case (state_ff)
         gtd_pkg::ST_NSQ: begin
            mul_a = MUL_W'(gsum_ff[ax]);
            mul_b = MUL_W'(gsum_ff[ax]);
         end
         gtd_pkg::ST_SQRT: begin
            sub_a = sq_n_ff;
            sub_b = sq_r_ff | sq_bit_ff;
         end
         gtd_pkg::ST_DIV: begin
            sub_a = rem_ff;
            sub_b = sq_r_ff << i_ff;
         end
         gtd_pkg::ST_DOT: begin
            mul_a = MUL_W'(v_ff[ax]);
            mul_b = MUL_W'(unit_ff[ax]);
         end
         gtd_pkg::ST_PERP: begin
            if (sub_ff == 2'd2) begin
               mul_a = MUL_W'(dd_ff);
               mul_b = MUL_W'(dd_ff);
            end else begin
               mul_a = MUL_W'(ax_ff);
               mul_b = MUL_W'(unit_ff[ax]);
            end
         end
         gtd_pkg::ST_ENERGY: begin
            mul_a = MUL_W'(v_ff[ax]);
            mul_b = MUL_W'(v_ff[ax]);
         end
         gtd_pkg::ST_WRITE:  ram_wr_en = 1'b1;
         gtd_pkg::ST_WSTART: ram_rd_en = 1'b1;
         gtd_pkg::ST_WA: begin
            mul_a = MUL_W'(d_ax);
            mul_b = MUL_W'(d_ax);
         end
         gtd_pkg::ST_WB: begin
            mul_a     = MUL_W'(d_pp);
            mul_b     = MUL_W'(d_pp);
            ram_rd_en = (k_ff != LAST_IDX);
         end
         default: ;
      endcase
   end

   // Datapath next values.
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      norm_in      = norm_ff;
      k_in         = k_ff;
      sub_in       = sub_ff;
      prod_in      = mul_p;
      acc_in       = acc_ff;
      h_in         = h_ff;
      sq_n_in      = sq_n_ff;
      sq_r_in      = sq_r_ff;
      sq_bit_in    = sq_bit_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      i_in         = i_ff;
      ax_in        = ax_ff;
      dd_in        = dd_ff;
      ptr_in       = ptr_ff;
      rd_idx_in    = rd_idx_ff;
      valid_in     = valid_ff;
      rvalid_in    = ram_rd_en ? valid_ff[ram_rd_addr] : rvalid_ff;
      err_in       = err_ff;
      errp_in      = errp_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_match_in = rsp_match_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      for (int n = 0; n < 3; n++) begin
         v_in[n]    = v_ff[n];
         gsum_in[n] = gsum_ff[n];
         unit_in[n] = unit_ff[n];
      end
      for (int n = 0; n < PW; n++) begin
         energy_in[n] = energy_ff[n];
      end
      unique case (state_ff)
         gtd_pkg::ST_IDLE: begin
            if (accept) begin
               v_in[0] = $signed(req_tdata[15:0]);
               v_in[1] = $signed(req_tdata[31:16]);
               v_in[2] = $signed(req_tdata[47:32]);
               k_in    = '0;
               acc_in  = '0;
            end
         end
         gtd_pkg::ST_CAL: begin
            // Summing starts once more than settle_samples samples have been counted.
            count_in = count_ff + 7'd1;
            phase_in = gtd_pkg::PHASE_CALIB;
            if (count_in > settle_ff) begin
               for (int n = 0; n < 3; n++) begin
                  gsum_in[n] = gsum_ff[n] + G_W'(v_ff[n]);
               end
            end
         end
         gtd_pkg::ST_NSQ, gtd_pkg::ST_DOT, gtd_pkg::ST_ENERGY: begin
            // The product of the previous cycle is added while the next one forms.
            if (k_ff != '0) acc_in = acc_ff + WIDE_W'(prod_ff);
            k_in = k_ff + PTR_W'(1);
         end
         gtd_pkg::ST_NCHK: begin
            // A zero gravity sum leaves the unit vector at zero.
            h_in     = '0;
            phase_in = gtd_pkg::PHASE_NORM;
            if (acc_ff == '0) norm_in = 1'b1;
         end
         gtd_pkg::ST_NSHIFT: begin
            if (acc_ff[WIDE_W-1:60] == '0) begin
               acc_in = acc_ff <<< 2;
               h_in   = h_ff + 5'd1;
            end else begin
               sq_n_in   = acc_ff;
               sq_r_in   = '0;
               sq_bit_in = WIDE_W'(1) << 60;
            end
         end
         gtd_pkg::ST_SQRT: begin
            // One step of the restoring square root per cycle.
            if (sub_ge) begin
               sq_n_in = sub_diff[WIDE_W-1:0];
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               acc_in = '0;
               k_in   = '0;
            end
         end
         gtd_pkg::ST_DIVINIT: begin
            rem_in = dividend;
            q_in   = '0;
            i_in   = 5'(Q_W - 1);
         end
         gtd_pkg::ST_DIV: begin
            if (sub_ge) begin
               rem_in = sub_diff[WIDE_W-1:0];
               q_in   = q_ff | (Q_W'(1) << i_ff);
            end
            i_in = i_ff - 5'd1;
         end
         gtd_pkg::ST_DIVEND: begin
            // The unit vector points against gravity.
            unit_in[ax] = (gsum_ff[ax] > 0) ? -$signed(q_sat) : $signed(q_sat);
            k_in        = k_ff + PTR_W'(1);
            if (k_ff == PTR_W'(2)) norm_in = 1'b1;
         end
         gtd_pkg::ST_AXIS: begin
            ax_in  = ax_sat;
            acc_in = '0;
            k_in   = '0;
            sub_in = 2'd0;
         end
         gtd_pkg::ST_PERP: begin
            unique case (sub_ff)
               2'd0: begin
                  if (k_ff != '0) acc_in = acc_ff + WIDE_W'(prod_ff);
                  if (k_ff == PTR_W'(3)) begin
                     sq_n_in   = WIDE_W'(acc_ff + WIDE_W'(prod_ff));
                     sq_r_in   = '0;
                     sq_bit_in = WIDE_W'(1) << 34;
                  end
                  sub_in = 2'd1;
               end
               2'd1: begin
                  dd_in  = perp_diff;
                  sub_in = 2'd2;
               end
               default: begin
                  sub_in = 2'd0;
                  k_in   = k_ff + PTR_W'(1);
               end
            endcase
         end
         gtd_pkg::ST_WRITE: begin
            valid_in[ptr_ff] = 1'b1;
            ptr_in    = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + PTR_W'(1);
            rd_idx_in = ptr_in;
            for (int n = 0; n < PW - 1; n++) begin
               energy_in[n] = energy_ff[n + 1];
            end
            energy_in[PW-1] = acc_ff[E_W-1:0];
            err_in  = '0;
            errp_in = '0;
            k_in    = '0;
         end
         gtd_pkg::ST_WSTART: begin
            rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + PTR_W'(1);
         end
         gtd_pkg::ST_WA: begin
            if (k_ff != '0) errp_in = errp_ff + prod_ff[ERR_W-1:0];
         end
         gtd_pkg::ST_WB: begin
            err_in = err_ff + prod_ff[ERR_W-1:0];
            if (k_ff != LAST_IDX) begin
               rd_idx_in = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + PTR_W'(1);
               k_in      = k_ff + PTR_W'(1);
            end
         end
         gtd_pkg::ST_WEND: begin
            errp_in  = errp_ff + prod_ff[ERR_W-1:0];
            phase_in = gtd_pkg::PHASE_DETECT;
         end
         gtd_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = phase_ff;
               rsp_match_in = (phase_ff == gtd_pkg::PHASE_DETECT) && match_now;
               rsp_hit_in   = (phase_ff == gtd_pkg::PHASE_DETECT) && hit_now;
            end
         end
         default: ;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gtd_pkg::ST_IDLE;
         count_ff     <= '0;
         norm_ff      <= 1'b0;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < 3; n++) begin
            gsum_ff[n] <= '0;
            unit_ff[n] <= '0;
         end
         for (int n = 0; n < PW; n++) begin
            energy_ff[n] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         norm_ff      <= norm_in;
         ptr_ff       <= ptr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int n = 0; n < 3; n++) begin
            gsum_ff[n] <= gsum_in[n];
            unit_ff[n] <= unit_in[n];
         end
         for (int n = 0; n < PW; n++) begin
            energy_ff[n] <= energy_in[n];
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      phase_ff     <= phase_in;
      k_ff         <= k_in;
      sub_ff       <= sub_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      h_ff         <= h_in;
      sq_n_ff      <= sq_n_in;
      sq_r_ff      <= sq_r_in;
      sq_bit_ff    <= sq_bit_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      i_ff         <= i_in;
      ax_ff        <= ax_in;
      dd_ff        <= dd_in;
      rd_idx_ff    <= rd_idx_in;
      rvalid_ff    <= rvalid_in;
      err_ff       <= err_in;
      errp_ff      <= errp_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_match_ff <= rsp_match_in;
      rsp_hit_ff   <= rsp_hit_in;
      for (int n = 0; n < 3; n++) begin
         v_ff[n] <= v_in[n];
      end
   end

   // Axial and perpendicular ring values share one memory word.
   gtd_ram #(
      .WIDTH(32),
      .DEPTH(TEMPLATE_LEN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_hit_ff, rsp_match_ff, rsp_phase_ff};

   // An accepted beat always takes the sequencer out of idle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("accepted beat did not start the sequencer");

   // Detection results only appear once the gravity axis is known.
   a_detect_needs_norm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_phase_ff == gtd_pkg::PHASE_DETECT)) |-> norm_ff)
      else $error("detection result before normalization");

   // Outside detection both flags are clear.
   a_flags_only_detect: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_phase_ff != gtd_pkg::PHASE_DETECT)) |->
      (!rsp_match_ff && !rsp_hit_ff))
      else $error("flag set outside detection");

   // The square-root step bit is always a single bit.
   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gtd_pkg::ST_SQRT) |-> $onehot(sq_bit_ff))
      else $error("square root step bit lost");

endmodule

/* sv/gtd_ram.sv */
module gtd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/tb.sv */
module tb;

   // One result of the detector, as the testbench predicts it.
   typedef struct packed {
      gtd_pkg::phase_type phase;
      logic               template_match;
      logic               hit_detected;
   } detect_result_type;

   // Template shapes, Q7.8, used both by the predictor and to build gestures.
   localparam int AXIAL_SHAPE [40] = '{
      -4142, -4314, -4513, -4748, -4992, -5181, -5363, -5482, -5471, -5195,
      -4621, -3773, -2876, -1972, -1169, -435, 241, 1006, 1450, 1774,
      1898, 1779, 1438, 923, 276, -410, -1113, -1848, -2555, -3219,
      -3830, -4327, -4626, -4854, -4909, -4884, -4783, -4601, -4480, -4359};
   localparam int PERP_SHAPE [40] = '{
      4412, 4126, 3684, 3141, 2588, 2175, 1874, 1718, 1703, 1843,
      2000, 2161, 2287, 2397, 2575, 2878, 3622, 4439, 4907, 5126,
      5105, 4872, 4445, 3829, 3175, 2631, 2097, 1683, 1429, 1288,
      1250, 1288, 1384, 1615, 1733, 1889, 2117, 2539, 2786, 3066};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // phase[1:0], template_match[2], hit_detected[3], zero
   logic        csr_wen;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   accel_gesture_template_detector_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor copy of the registers and of the detector state.
   longint unsigned lim_axial, lim_perp, lim_level, lim_rise, cfg_settle, cfg_calib;
   longint unsigned calib_count;
   bit              calibrated;
   longint          grav_sum [3];
   longint          grav_unit [3];
   longint          axial_hist [40];
   longint          perp_hist [40];
   int              hist_wr;
   longint          energy_hist [5];
   int              energy_wr;

   detect_result_type expected_q [$];
   detect_result_type got, want;
   int              error_count;
   int              send_idle_pct;
   int              recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Fixed-point rounding to nearest with ties toward +inf.
   function automatic longint rnd_shift(longint v, int sh);
      longint t;
      t = v + (longint'(1) <<< (sh - 1));
      if (t >= 0) return t >>> sh;
      return -longint'((longint'(-t) + ((longint'(1) << sh) - 1)) >> sh);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Turns the summed gravity into a negated unit vector in Q1.14.
   function automatic void derive_gravity_axis();
      longint unsigned n, nrm, mag, q;
      int h;
      n = 0;
      h = 0;
      for (int k = 0; k < 3; k++) n += longint'(grav_sum[k] * grav_sum[k]);
      if (n == 0) return;
      while (n < (64'd1 << 60)) begin
         n <<= 2;
         h++;
      end
      nrm = floor_sqrt(n);
      for (int k = 0; k < 3; k++) begin
         mag = longint'(grav_sum[k] < 0 ? -grav_sum[k] : grav_sum[k]) << (14 + h);
         q = (mag + nrm / 2) / nrm;
         if (q > 32767) q = 32767;
         grav_unit[k] = grav_sum[k] > 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic detect_result_type predict_detection(logic signed [15:0] ax,
                                                           logic signed [15:0] ay,
                                                           logic signed [15:0] az);
      detect_result_type r;
      longint v [3];
      longint a, sq, d, m, rise, lvl, e0, e1, e3, e4;
      longint unsigned p, err_a, err_p;
      int idx;
      v[0] = ax;
      v[1] = ay;
      v[2] = az;
      r = '0;
      if (!calibrated) begin
         if (calib_count < cfg_calib) begin
            calib_count++;
            if (calib_count > cfg_settle)
               for (int k = 0; k < 3; k++) grav_sum[k] += v[k];
            r.phase = gtd_pkg::PHASE_CALIB;
         end else begin
            derive_gravity_axis();
            calibrated = 1'b1;
            r.phase = gtd_pkg::PHASE_NORM;
         end
         return r;
      end
      a = 0;
      for (int k = 0; k < 3; k++) a += v[k] * grav_unit[k];
      a = rnd_shift(a, 14);
      if (a > 32767) a = 32767;
      if (a < -32768) a = -32768;
      sq = 0;
      for (int k = 0; k < 3; k++) begin
         d = v[k] - rnd_shift(a * grav_unit[k], 14);
         sq += d * d;
      end
      p = floor_sqrt(sq);
      if (p > 65535) p = 65535;
      axial_hist[hist_wr] = a;
      perp_hist[hist_wr] = p;
      hist_wr = (hist_wr + 1) % 40;
      energy_hist[energy_wr] = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
      energy_wr = (energy_wr + 1) % 5;
      // Template walk, oldest ring entry against the first template entry.
      err_a = 0;
      err_p = 0;
      for (int k = 0; k < 40; k++) begin
         idx = (k + hist_wr) % 40;
         d = AXIAL_SHAPE[k] - axial_hist[idx];
         err_a += d * d;
         d = PERP_SHAPE[k] - perp_hist[idx];
         err_p += d * d;
      end
      r.phase = gtd_pkg::PHASE_DETECT;
      r.template_match = err_a < (lim_axial << 16) && err_p < (lim_perp << 16);
      // Peak test on the middle of the last five squared magnitudes.
      lvl = lim_level << 16;
      rise = lim_rise << 16;
      m = energy_hist[(energy_wr + 2) % 5];
      e0 = m - energy_hist[energy_wr];
      e1 = m - energy_hist[(energy_wr + 1) % 5];
      e3 = m - energy_hist[(energy_wr + 3) % 5];
      e4 = m - energy_hist[(energy_wr + 4) % 5];
      r.hit_detected = m > lvl && ((e1 > rise && e4 > rise) || (e3 > rise && e0 > rise) ||
                                   (e3 > rise && e1 > rise));
      return r;
   endfunction

   // Sends one sample; the expectation is queued at the accepting edge.
   task automatic send_sample(int x, int y, int z);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {16'(z), 16'(y), 16'(x)};
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(predict_detection(16'(x), 16'(y), 16'(z)));
   endtask

   // Lets every expected result arrive, then allows the block to settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Register writes only happen with the block idle.
   task automatic write_reg(gtd_pkg::csr_index_type idx, int unsigned value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (idx)
         gtd_pkg::CSR_ERROR_LIMIT:      lim_axial = value & 16'hFFFF;
         gtd_pkg::CSR_PERP_ERROR_LIMIT: lim_perp  = value & 16'hFFFF;
         gtd_pkg::CSR_HIT_LEVEL:        lim_level = value & 16'hFFFF;
         gtd_pkg::CSR_HIT_RISE:         lim_rise  = value & 16'hFFFF;
         gtd_pkg::CSR_SETTLE_SAMPLES:   cfg_settle = value & 7'h7F;
         gtd_pkg::CSR_CALIB_END:        cfg_calib  = value & 7'h7F;
         default: ;
      endcase
   endtask

   task automatic set_limits(int unsigned ea, int unsigned ep, int unsigned lv,
                             int unsigned rs);
      write_reg(gtd_pkg::CSR_ERROR_LIMIT, ea);
      write_reg(gtd_pkg::CSR_PERP_ERROR_LIMIT, ep);
      write_reg(gtd_pkg::CSR_HIT_LEVEL, lv);
      write_reg(gtd_pkg::CSR_HIT_RISE, rs);
   endtask

   // One full gesture: the gravity axis is -z, so z = -axial and x carries the
   // perpendicular magnitude. Small noise keeps the error near the limits.
   task automatic send_gesture(int noise);
      for (int k = 0; k < 40; k++)
         send_sample(PERP_SHAPE[k] + $urandom_range(2 * noise) - noise,
                     $urandom_range(2 * noise) - noise,
                     -AXIAL_SHAPE[k] + $urandom_range(2 * noise) - noise);
   endtask

   // A short burst of five samples with a large middle one.
   task automatic send_peak();
      int base, top;
      base = $urandom_range(3000);
      top  = 8000 + $urandom_range(24000);
      send_sample(0, base, 2511);
      send_sample(base, 0, 2511);
      send_sample($urandom_range(1) ? top : -top, 0, 2511);
      send_sample(0, 0, 2511 - base);
      send_sample(0, -base, 2511);
   endtask

   function automatic int rand_field();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 32767 : -32768;
         1: return int'($urandom_range(600)) - 300;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   // Calibration: the first two samples are skipped, so they carry the field
   // extremes; the summed ones lie on +z so that the axis comes out exact.
   task automatic test_calibration();
      write_reg(gtd_pkg::CSR_CALIB_END, 127);
      write_reg(gtd_pkg::CSR_SETTLE_SAMPLES, 127);
      write_reg(gtd_pkg::CSR_SETTLE_SAMPLES, 2);
      write_reg(gtd_pkg::CSR_CALIB_END, 6);
      send_sample(-32768, 32767, -32768);
      send_sample(32767, -32768, 32767);
      repeat (4) send_sample(0, 0, 2511);
      // The normalizing sample is discarded.
      send_sample(-32768, -32768, -32768);
      drain();
      // These writes land after normalization and must change nothing.
      write_reg(gtd_pkg::CSR_SETTLE_SAMPLES, 0);
      write_reg(gtd_pkg::CSR_CALIB_END, 127);
   endtask

   task automatic test_directed_detection();
      send_sample(32767, 32767, 32767);
      send_sample(-32768, -32768, -32768);
      send_sample(0, 0, 0);
      send_sample(32767, -32768, 0);
      send_sample(0, 0, -32768);
      send_sample(0, 0, 32767);
      send_peak();
      drain();
      set_limits(65535, 65535, 0, 0);
      send_gesture(0);
      drain();
      set_limits(0, 0, 65535, 65535);
      send_peak();
      drain();
      set_limits(2000, 2500, 800, 400);
   endtask

   // A random mix of well-formed gestures, peaks and runs of random noise.
   task automatic test_random(int idle_pct, int stall_pct, int items);
      int sent, pick;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            send_gesture($urandom_range(60));
            sent += 40;
         end else if (pick < 45) begin
            send_peak();
            sent += 5;
         end else begin
            repeat (8) send_sample(rand_field(), rand_field(), rand_field());
            sent += 8;
         end
      end
      drain();
   endtask

   // Results are taken at the edge where both handshake signals are high.
   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{phase: gtd_pkg::phase_type'(rsp_tdata[1:0]),
                 template_match: rsp_tdata[2], hit_detected: rsp_tdata[3]};
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %p", $realtime, got);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (got.phase !== want.phase) begin
               $display("%0t: phase: expected %0d, actual %0d", $realtime, want.phase,
                        got.phase);
               error_count++;
            end
            if (got.template_match !== want.template_match) begin
               $display("%0t: template_match: expected %0b, actual %0b", $realtime,
                        want.template_match, got.template_match);
               error_count++;
            end
            if (got.hit_detected !== want.hit_detected) begin
               $display("%0t: hit_detected: expected %0b, actual %0b", $realtime,
                        want.hit_detected, got.hit_detected);
               error_count++;
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("[accel_gesture_template_detector_core] ERROR");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_wen        = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // Predictor state after reset.
      lim_axial  = 2000;
      lim_perp   = 2500;
      lim_level  = 800;
      lim_rise   = 400;
      cfg_settle = 40;
      cfg_calib  = 80;
      calib_count = 0;
      calibrated  = 1'b0;
      hist_wr     = 0;
      energy_wr   = 0;
      for (int k = 0; k < 3; k++) begin
         grav_sum[k]  = 0;
         grav_unit[k] = 0;
      end
      for (int k = 0; k < 40; k++) begin
         axial_hist[k] = 0;
         perp_hist[k]  = 0;
      end
      for (int k = 0; k < 5; k++) energy_hist[k] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_calibration();
      test_directed_detection();
      test_random(0, 0, 215);
      set_limits(1500, 4000, 2000, 1000);
      test_random(82, 0, 215);
      set_limits(8000, 1000, 100, 50);
      test_random(0, 82, 215);
      set_limits(2000, 2500, 800, 400);
      test_random(30, 30, 215);

      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("[accel_gesture_template_detector_core] OK");
      end else begin
         $display("[accel_gesture_template_detector_core] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/gtd_pkg.sv
sv/gtd_ram.sv
sv/accel_gesture_template_detector_core.sv
tb/tb.sv
